@@ rtl/core/swtfs_pkg.sv @@
// Shared constants and codes for the sliding-window top-frequency sum block.
// No dependencies; imported by the RAM-based top level and the checker.
package swtfs_pkg;

  localparam int unsigned WindowMaxDef = 256;
  localparam int unsigned ValueBitsDef = 32;
  localparam int unsigned SumW         = 40;
  localparam int unsigned CfgW         = 9;
  localparam int unsigned ApbAddrW     = 3;
  localparam int unsigned ApbDataW     = 32;

  // register index as decoded from paddr[2]
  localparam logic RegWindowLen = 1'b0;
  localparam logic RegTopCount  = 1'b1;

endpackage

@@ rtl/core/swtfs_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module swtfs_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                       wdata_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                       rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ rtl/core/sliding_window_top_frequency_sum_top.sv @@
// Top level of the sliding-window top-frequency sum: APB registers, sequencer,
// window RAM and rank-ordered list RAM. Depends on swtfs_pkg and swtfs_ram.
//
// Each beat on the input channel pushes one value into a window of window_len
// values; once the window is full the block returns the sum of count*value over
// the top_count most frequent distinct values (ties go to the larger value).
// Distinct values are kept in one RAM already sorted by rank, so every item is
// handled by one sequencer walking that RAM through its single read port: a
// lookup scan (one entry per cycle), a bubble step for the changed entry (a read
// state and a compare state per position moved) or a compaction when an entry
// empties (one cycle per entry), done once for the evicted value and once for
// the new one, then a summing pass of one entry per cycle over at most
// top_count entries. After window_len shrinks, each extra value dropped adds
// one more eviction pass. in_ready_o is high only while the sequencer is idle;
// a finished result waits in the output register while the next item is taken.
// No clearing pass is needed after reset: list length and fill count bound
// every read.
module sliding_window_top_frequency_sum_top #(
  parameter int unsigned WINDOW_MAX = swtfs_pkg::WindowMaxDef,
  parameter int unsigned VALUE_BITS = swtfs_pkg::ValueBitsDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // APB configuration
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [swtfs_pkg::ApbAddrW-1:0]     paddr,
  input  logic [swtfs_pkg::ApbDataW-1:0]     pwdata,
  output logic [swtfs_pkg::ApbDataW-1:0]     prdata,
  output logic                               pready,
  // input channel
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [31:0]                        sample_value_i,
  input  logic                               restart_i,
  // result channel
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [swtfs_pkg::SumW-1:0]         window_sum_o
);
  import swtfs_pkg::*;

  localparam int unsigned AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int unsigned CW = $clog2(WINDOW_MAX + 1);
  localparam int unsigned LW = (CW > CfgW) ? CW : CfgW;
  localparam int unsigned VB = VALUE_BITS;
  localparam int unsigned EW = VB + CW;
  localparam int unsigned PW = VB + CW;

  typedef enum logic [9:0] {
    S_IDLE    = 10'b00_0000_0001,
    S_CHK     = 10'b00_0000_0010,
    S_OLD     = 10'b00_0000_0100,
    S_FIND    = 10'b00_0000_1000,
    S_SHIFT   = 10'b00_0001_0000,
    S_BUB_RD  = 10'b00_0010_0000,
    S_BUB_CMP = 10'b00_0100_0000,
    S_WIN     = 10'b00_1000_0000,
    S_SUM     = 10'b01_0000_0000,
    S_OUT     = 10'b10_0000_0000
  } state_e;

  // ---------------------------------------------------------------- registers
  logic [CfgW-1:0] win_len_q, win_len_d, top_cnt_q, top_cnt_d;

  state_e          state_q, state_d;
  logic            op_add_q, op_add_d;
  logic            dir_up_q, dir_up_d;
  logic [VB-1:0]   key_q, key_d;
  logic [VB-1:0]   new_val_q, new_val_d;
  logic [CW-1:0]   w_q, w_d, fill_q, fill_d, len_q, len_d;
  logic [AW-1:0]   ws_q, ws_d;
  logic [CW-1:0]   scan_q, scan_d, chk_a_q, chk_a_d, pos_q, pos_d, lim_q, lim_d;
  logic            chk_v_q, chk_v_d, s1_q, s1_d, s2_q, s2_d;
  logic [VB-1:0]   cur_val_q, cur_val_d;
  logic [CW-1:0]   cur_cnt_q, cur_cnt_d;
  logic [PW-1:0]   prod_q, prod_d;
  logic [SumW-1:0] sum_q, sum_d, out_sum_q, out_sum_d;
  logic            out_valid_q, out_valid_d;

  // ---------------------------------------------------------------- RAM ports
  logic            wwe, lwe;
  logic [AW-1:0]   wwaddr, wraddr, lwaddr, lraddr;
  logic [VB-1:0]   wrdata;
  logic [EW-1:0]   lwdata, lrdata;

  swtfs_ram #(.Width(VB), .Depth(WINDOW_MAX)) u_win_ram (
    .clk_i   (clk_i),
    .we_i    (wwe),
    .waddr_i (wwaddr),
    .wdata_i (new_val_q),
    .raddr_i (wraddr),
    .rdata_o (wrdata)
  );

  swtfs_ram #(.Width(EW), .Depth(WINDOW_MAX)) u_list_ram (
    .clk_i   (clk_i),
    .we_i    (lwe),
    .waddr_i (lwaddr),
    .wdata_i (lwdata),
    .raddr_i (lraddr),
    .rdata_o (lrdata)
  );

  logic [VB-1:0] rd_val;
  logic [CW-1:0] rd_cnt;
  assign rd_val = lrdata[VB-1:0];
  assign rd_cnt = lrdata[EW-1:VB];

  // ---------------------------------------------------------------- APB
  logic cfg_wr;
  assign cfg_wr = psel & penable & pwrite;
  assign pready = 1'b1;

  always_comb begin
    win_len_d = win_len_q;
    top_cnt_d = top_cnt_q;
    if (cfg_wr) begin
      case (paddr[2])
        RegWindowLen: win_len_d = pwdata[CfgW-1:0];
        RegTopCount:  top_cnt_d = pwdata[CfgW-1:0];
        default:      win_len_d = win_len_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      RegWindowLen: prdata = ApbDataW'(win_len_q);
      RegTopCount:  prdata = ApbDataW'(top_cnt_q);
      default:      prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- helpers
  logic [LW-1:0] len_x, w_eff_x, top_x, len_lw;
  logic [CW-1:0] w_eff, lim_new;
  assign len_x   = LW'(win_len_q);
  assign w_eff_x = (len_x == '0) ? LW'(1) :
                   (len_x > LW'(WINDOW_MAX)) ? LW'(WINDOW_MAX) : len_x;
  assign w_eff   = w_eff_x[CW-1:0];
  assign top_x   = LW'(top_cnt_q);
  assign len_lw  = LW'(len_q);
  assign lim_new = (top_x < len_lw) ? top_x[CW-1:0] : len_q;

  // oldest window slot: (ws - fill) mod WINDOW_MAX
  logic [CW:0] old_raw, old_slot;
  assign old_raw  = (CW+1)'(ws_q) + (CW+1)'(WINDOW_MAX) - (CW+1)'(fill_q);
  assign old_slot = (old_raw >= (CW+1)'(WINDOW_MAX)) ? old_raw - (CW+1)'(WINDOW_MAX)
                                                     : old_raw;

  logic [AW-1:0] ws_inc;
  assign ws_inc = (ws_q == AW'(WINDOW_MAX - 1)) ? '0 : ws_q + AW'(1);

  logic          bub_edge;
  logic [CW-1:0] nb_pos;
  assign bub_edge = dir_up_q ? (pos_q == '0)
                             : ((CW+1)'(pos_q) + (CW+1)'(1) >= (CW+1)'(len_q));
  assign nb_pos   = dir_up_q ? pos_q - CW'(1) : pos_q + CW'(1);

  logic cur_above_nb, nb_above_cur, move_nb;
  assign cur_above_nb = (cur_cnt_q != rd_cnt) ? (cur_cnt_q > rd_cnt) : (cur_val_q > rd_val);
  assign nb_above_cur = (cur_cnt_q != rd_cnt) ? (rd_cnt > cur_cnt_q) : (rd_val > cur_val_q);
  assign move_nb      = dir_up_q ? cur_above_nb : nb_above_cur;

  logic [SumW:0] sum_add;
  assign sum_add = {1'b0, sum_q} + (SumW+1)'(prod_q);

  logic in_acc;
  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i & in_ready_o;

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_d     = state_q;
    op_add_d    = op_add_q;
    dir_up_d    = dir_up_q;
    key_d       = key_q;
    new_val_d   = new_val_q;
    w_d         = w_q;
    fill_d      = fill_q;
    len_d       = len_q;
    ws_d        = ws_q;
    scan_d      = scan_q;
    chk_v_d     = chk_v_q;
    chk_a_d     = chk_a_q;
    pos_d       = pos_q;
    lim_d       = lim_q;
    s1_d        = s1_q;
    s2_d        = s2_q;
    cur_val_d   = cur_val_q;
    cur_cnt_d   = cur_cnt_q;
    prod_d      = prod_q;
    sum_d       = sum_q;
    out_sum_d   = out_sum_q;
    out_valid_d = out_valid_q;
    wwe         = 1'b0;
    wwaddr      = ws_q;
    wraddr      = old_slot[AW-1:0];
    lwe         = 1'b0;
    lwaddr      = pos_q[AW-1:0];
    lwdata      = {cur_cnt_q, cur_val_q};
    lraddr      = scan_q[AW-1:0];

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          key_d     = sample_value_i[VB-1:0];
          new_val_d = sample_value_i[VB-1:0];
          w_d       = w_eff;
          if (restart_i) begin
            fill_d = '0;
            ws_d   = '0;
            len_d  = '0;
          end
          state_d = S_CHK;
        end
      end

      S_CHK: begin
        if (fill_q >= w_q) begin
          state_d = S_OLD;   // read of the oldest slot issued here
        end else begin
          state_d = S_WIN;
        end
      end

      S_OLD: begin
        key_d    = wrdata;
        op_add_d = 1'b0;
        scan_d   = '0;
        chk_v_d  = 1'b0;
        state_d  = S_FIND;
      end

      S_WIN: begin
        wwe      = 1'b1;
        key_d    = new_val_q;
        ws_d     = ws_inc;
        fill_d   = fill_q + CW'(1);
        op_add_d = 1'b1;
        scan_d   = '0;
        chk_v_d  = 1'b0;
        state_d  = S_FIND;
      end

      S_FIND: begin
        // one read issued per cycle; each entry is compared in the next cycle, when its data returns
        if (scan_q < len_q) begin
          chk_v_d = 1'b1;
          chk_a_d = scan_q;
          scan_d  = scan_q + CW'(1);
        end else begin
          chk_v_d = 1'b0;
        end
        if (chk_v_q && rd_val == key_q) begin
          chk_v_d   = 1'b0;
          pos_d     = chk_a_q;
          cur_val_d = key_q;
          if (op_add_q) begin
            cur_cnt_d = rd_cnt + CW'(1);
            dir_up_d  = 1'b1;
            state_d   = S_BUB_RD;
          end else if (rd_cnt == CW'(1)) begin
            scan_d  = chk_a_q + CW'(1);
            state_d = S_SHIFT;
          end else begin
            cur_cnt_d = rd_cnt - CW'(1);
            dir_up_d  = 1'b0;
            state_d   = S_BUB_RD;
          end
        end else if ((chk_v_q && chk_a_q == len_q - CW'(1)) || len_q == '0) begin
          chk_v_d = 1'b0;
          if (op_add_q) begin
            cur_val_d = key_q;
            cur_cnt_d = CW'(1);
            pos_d     = len_q;
            len_d     = len_q + CW'(1);
            dir_up_d  = 1'b1;
            state_d   = S_BUB_RD;
          end else begin
            fill_d  = fill_q - CW'(1);
            state_d = S_CHK;
          end
        end
      end

      S_SHIFT: begin
        // close the gap left by an emptied entry
        if (scan_q < len_q) begin
          chk_v_d = 1'b1;
          chk_a_d = scan_q;
          scan_d  = scan_q + CW'(1);
        end else begin
          chk_v_d = 1'b0;
        end
        if (chk_v_q) begin
          lwe    = 1'b1;
          lwaddr = AW'(chk_a_q - CW'(1));
          lwdata = lrdata;
        end
        if (scan_q >= len_q && !chk_v_q) begin
          len_d   = len_q - CW'(1);
          fill_d  = fill_q - CW'(1);
          state_d = S_CHK;
        end
      end

      S_BUB_RD, S_BUB_CMP: begin
        if (state_q == S_BUB_RD && !bub_edge) begin
          lraddr  = nb_pos[AW-1:0];
          state_d = S_BUB_CMP;
        end else if (state_q == S_BUB_CMP && move_nb) begin
          lwe     = 1'b1;
          lwdata  = lrdata;
          pos_d   = nb_pos;
          state_d = S_BUB_RD;
        end else begin
          lwe = 1'b1;
          if (!op_add_q) begin
            fill_d  = fill_q - CW'(1);
            state_d = S_CHK;
          end else if (fill_q == w_q) begin
            scan_d  = '0;
            lim_d   = lim_new;
            sum_d   = '0;
            s1_d    = 1'b0;
            s2_d    = 1'b0;
            state_d = S_SUM;
          end else begin
            state_d = S_IDLE;
          end
        end
      end

      S_SUM: begin
        if (scan_q < lim_q) begin
          s1_d   = 1'b1;
          scan_d = scan_q + CW'(1);
        end else begin
          s1_d = 1'b0;
        end
        s2_d = s1_q;
        if (s1_q) begin
          prod_d = PW'(rd_cnt) * PW'(rd_val);
        end
        if (s2_q) begin
          sum_d = sum_add[SumW] ? {SumW{1'b1}} : sum_add[SumW-1:0];
        end
        if (scan_q >= lim_q && !s1_q && !s2_q) begin
          state_d = S_OUT;
        end
      end

      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_sum_d   = sum_q;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_len_q   <= CfgW'(1);
      top_cnt_q   <= CfgW'(1);
      state_q     <= S_IDLE;
      op_add_q    <= 1'b0;
      dir_up_q    <= 1'b0;
      w_q         <= CW'(1);
      fill_q      <= '0;
      len_q       <= '0;
      ws_q        <= '0;
      scan_q      <= '0;
      chk_v_q     <= 1'b0;
      chk_a_q     <= '0;
      pos_q       <= '0;
      lim_q       <= '0;
      s1_q        <= 1'b0;
      s2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      win_len_q   <= win_len_d;
      top_cnt_q   <= top_cnt_d;
      state_q     <= state_d;
      op_add_q    <= op_add_d;
      dir_up_q    <= dir_up_d;
      w_q         <= w_d;
      fill_q      <= fill_d;
      len_q       <= len_d;
      ws_q        <= ws_d;
      scan_q      <= scan_d;
      chk_v_q     <= chk_v_d;
      chk_a_q     <= chk_a_d;
      pos_q       <= pos_d;
      lim_q       <= lim_d;
      s1_q        <= s1_d;
      s2_q        <= s2_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q     <= key_d;
    new_val_q <= new_val_d;
    cur_val_q <= cur_val_d;
    cur_cnt_q <= cur_cnt_d;
    prod_q    <= prod_d;
    sum_q     <= sum_d;
    out_sum_q <= out_sum_d;
  end

  assign out_valid_o  = out_valid_q;
  assign window_sum_o = out_sum_q;

endmodule

@@ rtl/core/swtfs_checker.sv @@
// Port-level checker for the sliding-window top-frequency sum, with its bind.
// Depends on swtfs_pkg and on the top level's ports.
module swtfs_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_o,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic [swtfs_pkg::SumW-1:0]     window_sum_o,
  input logic                           pready
);
  import swtfs_pkg::*;

  // a result beat holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(window_sum_o))
    else $error("result beat dropped or changed while stalled");

  // an accepted beat leaves the sequencer busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken again right after a beat");

  // a new result only comes out of a busy sequencer
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared without work in progress");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready dropped");

endmodule

bind sliding_window_top_frequency_sum_top swtfs_checker u_swtfs_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .window_sum_o (window_sum_o),
  .pready       (pready)
);
